FILE: design/qpr_pkg.sv
// Shared types, constants and the arctangent table of the quaternion point rotator.
`timescale 1ns / 1ps
`default_nettype none

package qpr_pkg;

  localparam int COORD_WIDTH_DEF  = 32;
  localparam int CORDIC_STEPS_DEF = 24;
  localparam int CORDIC_MAX       = 32;

  localparam int WORD_W    = 32;
  localparam int CFG_IDX_W = 3;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z = 3'd6;

  localparam logic signed [WORD_W-1:0] ONE_Q30 = 32'sd1073741824;
  localparam logic signed [32:0] CORDIC_INV_GAIN = 33'sd652032874;

  typedef enum logic [2:0] {
    BLD_IDLE,
    BLD_LOAD,
    BLD_CORDIC,
    BLD_MUL,
    BLD_FLUSH,
    BLD_MATRIX
  } qpr_bld_state_t;

  // Settings handed from the matrix builder to the point datapath
  typedef struct packed {
    logic                   busy;
    logic [2:0][WORD_W-1:0] center;
    logic [8:0][WORD_W-1:0] matrix;
  } qpr_cfg_t;

  // atan(2^-i) in units of 2^-32 of a turn
  function automatic logic [29:0] atan_lut(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      5'd24: v = 30'd41;
      5'd25: v = 30'd20;
      5'd26: v = 30'd10;
      5'd27: v = 30'd5;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      5'd30: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: design/qpr_builder.sv
// Configuration registers and the sequencer that builds the rotation matrix.
`timescale 1ns / 1ps
`default_nettype none

module qpr_builder #(
  parameter int CORDIC_STEPS = qpr_pkg::CORDIC_STEPS_DEF
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               cfg_wr_en,
  input  wire  [qpr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [qpr_pkg::WORD_W-1:0]        cfg_data,
  output qpr_pkg::qpr_cfg_t                 cfg
);

  localparam int CORDIC_RUNS = (CORDIC_STEPS > qpr_pkg::CORDIC_MAX) ? qpr_pkg::CORDIC_MAX :
                               CORDIC_STEPS;
  localparam logic [4:0] LAST_STEP = 5'(CORDIC_RUNS - 1);

  // Product slots of the shared multiplier, in issue order
  localparam logic [3:0] P_AXX = 4'd0;
  localparam logic [3:0] P_AXY = 4'd1;
  localparam logic [3:0] P_AXZ = 4'd2;
  localparam logic [3:0] P_AA  = 4'd3;
  localparam logic [3:0] P_BB  = 4'd4;
  localparam logic [3:0] P_CC  = 4'd5;
  localparam logic [3:0] P_DD  = 4'd6;
  localparam logic [3:0] P_BC  = 4'd7;
  localparam logic [3:0] P_AD  = 4'd8;
  localparam logic [3:0] P_BD  = 4'd9;
  localparam logic [3:0] P_AC  = 4'd10;
  localparam logic [3:0] P_CD  = 4'd11;
  localparam logic [3:0] P_AB  = 4'd12;

  localparam logic signed [65:0] HALF_Q30_66 = 66'sd536870912;
  localparam logic signed [63:0] HALF_Q30_64 = 64'sd536870912;

  logic [qpr_pkg::WORD_W-1:0] axis_x, axis_y, axis_z, angle;
  logic [qpr_pkg::WORD_W-1:0] center_x, center_y, center_z;

  qpr_pkg::qpr_bld_state_t state, state_next;
  logic [4:0] cnt;
  logic       rebuild;

  logic signed [32:0] x, y;
  logic signed [34:0] z;
  logic               neg_cos;

  logic signed [32:0] dx, dy;
  logic signed [34:0] dz;
  logic signed [32:0] cs;
  logic signed [31:0] a_w;

  logic signed [32:0] opa, opb;
  logic signed [65:0] prod;
  logic [3:0]         prod_slot;
  logic               prod_vld;

  logic signed [65:0] prod_rnd;
  logic signed [36:0] prod_neg;

  logic signed [31:0] qb, qc, qd;
  logic signed [61:0] pr_aa, pr_bb, pr_cc, pr_dd, pr_bc, pr_ad, pr_bd, pr_ac, pr_cd, pr_ab;

  logic signed [63:0] m_sum [9];
  logic [8:0][qpr_pkg::WORD_W-1:0] matrix;

  function automatic logic signed [31:0] clamp_q30(input logic signed [36:0] v);
    logic signed [36:0] hi;
    logic signed [36:0] lo;
    hi = 37'(qpr_pkg::ONE_Q30);
    lo = -hi;
    if (v > hi) return 32'(hi);
    if (v < lo) return 32'(lo);
    return 32'(v);
  endfunction

  function automatic logic [31:0] rnd_sat32(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = (v + HALF_Q30_64) >>> 30;
    if (r > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (r < -64'sd2147483648) return 32'h8000_0000;
    return r[31:0];
  endfunction

  assign rebuild = cfg_wr_en && (cfg_index <= qpr_pkg::REG_ANGLE);

  // Register file
  always_ff @(posedge clk) begin
    if (rst) begin
      axis_x   <= '0;
      axis_y   <= '0;
      axis_z   <= qpr_pkg::ONE_Q30;
      angle    <= '0;
      center_x <= '0;
      center_y <= '0;
      center_z <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        qpr_pkg::REG_AXIS_X:   axis_x   <= cfg_data;
        qpr_pkg::REG_AXIS_Y:   axis_y   <= cfg_data;
        qpr_pkg::REG_AXIS_Z:   axis_z   <= cfg_data;
        qpr_pkg::REG_ANGLE:    angle    <= cfg_data;
        qpr_pkg::REG_CENTER_X: center_x <= cfg_data;
        qpr_pkg::REG_CENTER_Y: center_y <= cfg_data;
        qpr_pkg::REG_CENTER_Z: center_z <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= qpr_pkg::BLD_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      qpr_pkg::BLD_IDLE:   state_next = qpr_pkg::BLD_IDLE;
      qpr_pkg::BLD_LOAD:   state_next = qpr_pkg::BLD_CORDIC;
      qpr_pkg::BLD_CORDIC: if (cnt == LAST_STEP) state_next = qpr_pkg::BLD_MUL;
      qpr_pkg::BLD_MUL:    if (cnt[3:0] == P_AB) state_next = qpr_pkg::BLD_FLUSH;
      qpr_pkg::BLD_FLUSH:  state_next = qpr_pkg::BLD_MATRIX;
      qpr_pkg::BLD_MATRIX: state_next = qpr_pkg::BLD_IDLE;
      default:             state_next = qpr_pkg::BLD_IDLE;
    endcase
    // a new axis or angle restarts the build from the top
    if (rebuild) state_next = qpr_pkg::BLD_LOAD;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (state == qpr_pkg::BLD_LOAD ||
                 (state == qpr_pkg::BLD_CORDIC && cnt == LAST_STEP)) begin
      cnt <= '0;
    end else if (state == qpr_pkg::BLD_CORDIC || state == qpr_pkg::BLD_MUL) begin
      cnt <= cnt + 5'd1;
    end
  end

  // CORDIC rotation, one step per cycle
  always_comb begin
    dx = y >>> cnt;
    dy = x >>> cnt;
    dz = 35'({qpr_pkg::atan_lut(cnt), 1'b0});
  end

  always_ff @(posedge clk) begin
    if (state == qpr_pkg::BLD_LOAD) begin
      x       <= qpr_pkg::CORDIC_INV_GAIN;
      y       <= '0;
      neg_cos <= angle[31];
      // beyond a quarter turn of half angle, rotate by the supplement
      z       <= angle[31] ? 35'(33'h1_0000_0000 - {1'b0, angle}) : 35'({1'b0, angle});
    end else if (state == qpr_pkg::BLD_CORDIC) begin
      if (!z[34]) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - dz;
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + dz;
      end
    end
  end

  assign cs  = neg_cos ? -x : x;
  assign a_w = clamp_q30(37'(cs));

  // Shared multiplier, operands picked by the product slot
  always_comb begin
    case (cnt[3:0])
      P_AXX:   begin opa = 33'($signed(axis_x)); opb = y; end
      P_AXY:   begin opa = 33'($signed(axis_y)); opb = y; end
      P_AXZ:   begin opa = 33'($signed(axis_z)); opb = y; end
      P_AA:    begin opa = 33'(a_w); opb = 33'(a_w); end
      P_BB:    begin opa = 33'(qb);  opb = 33'(qb);  end
      P_CC:    begin opa = 33'(qc);  opb = 33'(qc);  end
      P_DD:    begin opa = 33'(qd);  opb = 33'(qd);  end
      P_BC:    begin opa = 33'(qb);  opb = 33'(qc);  end
      P_AD:    begin opa = 33'(a_w); opb = 33'(qd);  end
      P_BD:    begin opa = 33'(qb);  opb = 33'(qd);  end
      P_AC:    begin opa = 33'(a_w); opb = 33'(qc);  end
      P_CD:    begin opa = 33'(qc);  opb = 33'(qd);  end
      P_AB:    begin opa = 33'(a_w); opb = 33'(qb);  end
      default: begin opa = '0;       opb = '0;       end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= (state == qpr_pkg::BLD_MUL);
    end
  end

  always_ff @(posedge clk) begin
    prod      <= 66'(opa) * 66'(opb);
    prod_slot <= cnt[3:0];
  end

  assign prod_rnd = (prod + HALF_Q30_66) >>> 30;
  assign prod_neg = -37'(prod_rnd);

  // Store each product in the cycle after it is issued
  always_ff @(posedge clk) begin
    if (prod_vld) begin
      case (prod_slot)
        P_AXX:   qb    <= clamp_q30(prod_neg);
        P_AXY:   qc    <= clamp_q30(prod_neg);
        P_AXZ:   qd    <= clamp_q30(prod_neg);
        P_AA:    pr_aa <= prod[61:0];
        P_BB:    pr_bb <= prod[61:0];
        P_CC:    pr_cc <= prod[61:0];
        P_DD:    pr_dd <= prod[61:0];
        P_BC:    pr_bc <= prod[61:0];
        P_AD:    pr_ad <= prod[61:0];
        P_BD:    pr_bd <= prod[61:0];
        P_AC:    pr_ac <= prod[61:0];
        P_CD:    pr_cd <= prod[61:0];
        P_AB:    pr_ab <= prod[61:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    m_sum[0] = 64'(pr_aa) + 64'(pr_bb) - 64'(pr_cc) - 64'(pr_dd);
    m_sum[1] = (64'(pr_bc) - 64'(pr_ad)) <<< 1;
    m_sum[2] = (64'(pr_bd) + 64'(pr_ac)) <<< 1;
    m_sum[3] = (64'(pr_bc) + 64'(pr_ad)) <<< 1;
    m_sum[4] = 64'(pr_aa) + 64'(pr_cc) - 64'(pr_bb) - 64'(pr_dd);
    m_sum[5] = (64'(pr_cd) - 64'(pr_ab)) <<< 1;
    m_sum[6] = (64'(pr_bd) - 64'(pr_ac)) <<< 1;
    m_sum[7] = (64'(pr_cd) + 64'(pr_ab)) <<< 1;
    m_sum[8] = 64'(pr_aa) + 64'(pr_dd) - 64'(pr_bb) - 64'(pr_cc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) begin
        matrix[i] <= (i % 4 == 0) ? qpr_pkg::ONE_Q30 : '0;
      end
    end else if (state == qpr_pkg::BLD_MATRIX) begin
      for (int i = 0; i < 9; i++) begin
        matrix[i] <= rnd_sat32(m_sum[i]);
      end
    end
  end

  assign cfg.busy      = (state != qpr_pkg::BLD_IDLE);
  assign cfg.center[0] = center_x;
  assign cfg.center[1] = center_y;
  assign cfg.center[2] = center_z;
  assign cfg.matrix    = matrix;

endmodule

`default_nettype wire

FILE: design/qpr_datapath.sv
// Point pipeline: centering, matrix product, rounding, re-centering and saturation.
`timescale 1ns / 1ps
`default_nettype none

module qpr_datapath #(
  parameter int COORD_WIDTH = qpr_pkg::COORD_WIDTH_DEF
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire  qpr_pkg::qpr_cfg_t            cfg,
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire  [2:0][qpr_pkg::WORD_W-1:0]    in_pt,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic [2:0][qpr_pkg::WORD_W-1:0]    new_pt,
  output logic [2:0][qpr_pkg::WORD_W-1:0]    disp_pt,
  output logic                               overflow
);

  localparam int CW     = (COORD_WIDTH > qpr_pkg::WORD_W) ? qpr_pkg::WORD_W : COORD_WIDTH;
  localparam int SH     = qpr_pkg::WORD_W - CW;
  localparam int Q_W    = 33;
  localparam int PROD_W = 65;
  localparam int SUM_W  = 67;
  localparam int ROT_W  = 37;
  localparam int NV_W   = 38;
  localparam int DV_W   = 39;
  localparam int NSTG   = 6;

  localparam logic signed [DV_W-1:0] SAT_HI = DV_W'((64'sd1 <<< (CW - 1)) - 64'sd1);
  localparam logic signed [DV_W-1:0] SAT_LO = ~SAT_HI;
  localparam logic signed [SUM_W-1:0] HALF_Q30 = 67'sd536870912;

  logic [NSTG:1]   vld;
  logic [NSTG+1:1] rdy;
  logic            accept;

  logic signed [31:0]       p1 [3];
  logic signed [31:0]       p2 [3];
  logic signed [31:0]       p3 [3];
  logic signed [31:0]       p4 [3];
  logic signed [31:0]       p5 [3];
  logic signed [Q_W-1:0]    q2 [3];
  logic signed [PROD_W-1:0] pr3 [3][3];
  logic signed [ROT_W-1:0]  rot4 [3];
  logic signed [NV_W-1:0]   nv5 [3];

  logic [31:0]              p_in [3];
  logic signed [SUM_W-1:0]  sum3 [3];
  logic [32:0]              sat_n [3];
  logic [32:0]              sat_d [3];

  function automatic logic [32:0] sat_coord(input logic signed [DV_W-1:0] v);
    if (v > SAT_HI) return {1'b1, SAT_HI[31:0]};
    if (v < SAT_LO) return {1'b1, SAT_LO[31:0]};
    return {1'b0, v[31:0]};
  endfunction

  // Ready ripples back from the output; a bubble anywhere lets the input advance
  always_comb begin
    rdy[NSTG+1] = out_ready;
    for (int k = NSTG; k >= 1; k--) begin
      rdy[k] = ~vld[k] | rdy[k+1];
    end
  end

  assign in_ready = rdy[1] & ~cfg.busy;
  assign accept   = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[1]) vld[1] <= accept;
      for (int k = 2; k <= NSTG; k++) begin
        if (rdy[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // Keep the low CW bits of each coordinate, sign-extended
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p_in[i] = in_pt[i] << SH;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      for (int i = 0; i < 3; i++) p1[i] <= $signed(p_in[i]) >>> SH;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      for (int i = 0; i < 3; i++) begin
        p2[i] <= p1[i];
        q2[i] <= Q_W'(p1[i]) - Q_W'($signed(cfg.center[i]));
      end
    end
  end

  // out_j = sum_i q_i * M[i][j]
  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      for (int j = 0; j < 3; j++) begin
        p3[j] <= p2[j];
        for (int i = 0; i < 3; i++) begin
          pr3[j][i] <= PROD_W'(q2[i]) * PROD_W'($signed(cfg.matrix[3*i+j]));
        end
      end
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      sum3[j] = SUM_W'(pr3[j][0]) + SUM_W'(pr3[j][1]) + SUM_W'(pr3[j][2]) + HALF_Q30;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      for (int j = 0; j < 3; j++) begin
        p4[j]   <= p3[j];
        rot4[j] <= sum3[j][SUM_W-1:30];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      for (int j = 0; j < 3; j++) begin
        p5[j]  <= p4[j];
        nv5[j] <= NV_W'(rot4[j]) + NV_W'($signed(cfg.center[j]));
      end
    end
  end

  // Displacement comes from the rotated point before saturation
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      sat_n[j] = sat_coord(DV_W'(nv5[j]));
      sat_d[j] = sat_coord(DV_W'(nv5[j]) - DV_W'(p5[j]));
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      for (int j = 0; j < 3; j++) begin
        new_pt[j]  <= sat_n[j][31:0];
        disp_pt[j] <= sat_d[j][31:0];
      end
      overflow <= sat_n[0][32] | sat_n[1][32] | sat_n[2][32] |
                  sat_d[0][32] | sat_d[1][32] | sat_d[2][32];
    end
  end

  assign out_valid = vld[NSTG];

endmodule

`default_nettype wire

FILE: design/quaternion_point_rotator.sv
// Quaternion point rotator: top level with stream channels and configuration port.
//
// Rotates Q16.16 points about a configured center and axis by a configured angle.
// Input stream s_axis carries one point per transaction; output stream m_axis
// carries the rotated point, the displacement and an overflow flag.
// Configuration: cfg_wr_en/cfg_index/cfg_data write one register per cycle,
// index 0..6 = axis_x, axis_y, axis_z, angle, center_x, center_y, center_z.
// A write to the axis or angle rebuilds the rotation matrix: CORDIC_STEPS
// (at most 32) CORDIC steps, 13 products on one shared multiplier plus a
// flush, and one matrix write, during which s_axis_tready stays low. Center
// writes take effect at once. Throughput is one point per cycle while the
// receiver is ready and no matrix build is running; an input transaction
// reaches m_axis_tvalid through the six registered pipeline stages.
// When the receiver stalls, results hold in the pipeline and bubbles are
// squeezed out, so input keeps flowing until all six stages are full.
// Reset clears the pipeline, loads the identity matrix, axis = +z, angle 0,
// center at the origin.
`timescale 1ns / 1ps
`default_nettype none

module quaternion_point_rotator #(
  parameter int COORD_WIDTH  = qpr_pkg::COORD_WIDTH_DEF,
  parameter int CORDIC_STEPS = qpr_pkg::CORDIC_STEPS_DEF
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            cfg_wr_en,
  input  wire  [qpr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [qpr_pkg::WORD_W-1:0]     cfg_data,
  input  wire                            s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire  [95:0]                    s_axis_tdata,  // init_x, init_y, init_z
  output logic                           m_axis_tvalid,
  input  wire                            m_axis_tready,
  output logic [199:0]                   m_axis_tdata   // new_x, new_y, new_z, disp_x,
                                                        // disp_y, disp_z, overflow, zeros
);

  qpr_pkg::qpr_cfg_t                 cfg;
  logic [2:0][qpr_pkg::WORD_W-1:0]   in_pt;
  logic [2:0][qpr_pkg::WORD_W-1:0]   new_pt;
  logic [2:0][qpr_pkg::WORD_W-1:0]   disp_pt;
  logic                              overflow;

  qpr_builder #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_builder (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign in_pt[0] = s_axis_tdata[31:0];
  assign in_pt[1] = s_axis_tdata[63:32];
  assign in_pt[2] = s_axis_tdata[95:64];

  qpr_datapath #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_pt     (in_pt),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .new_pt    (new_pt),
    .disp_pt   (disp_pt),
    .overflow  (overflow)
  );

  assign m_axis_tdata = {7'd0, overflow, disp_pt[2], disp_pt[1], disp_pt[0],
                         new_pt[2], new_pt[1], new_pt[0]};

endmodule

`default_nettype wire

FILE: bench/rotator_checker.sv
// Checker for the quaternion point rotator: predicts each rotated point and compares results.
`timescale 1ns / 1ps

module rotator_checker #(
  parameter int COORD_WIDTH  = qpr_pkg::COORD_WIDTH_DEF,
  parameter int CORDIC_STEPS = qpr_pkg::CORDIC_STEPS_DEF
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           cfg_wr_en,
  input  wire  [qpr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire  [qpr_pkg::WORD_W-1:0]    cfg_data,
  input  wire                           s_axis_tvalid,
  input  wire                           s_axis_tready,
  input  wire  [95:0]                   s_axis_tdata,  // init_x, init_y, init_z
  input  wire                           m_axis_tvalid,
  input  wire                           m_axis_tready,
  input  wire  [199:0]                  m_axis_tdata,  // new_x, new_y, new_z, disp_x,
                                                       // disp_y, disp_z, overflow, zeros
  output int                            fail_count,
  output int                            pending
);
  import qpr_pkg::*;

  localparam int CW_EFF    = COORD_WIDTH > 32 ? 32 : (COORD_WIDTH < 2 ? 2 : COORD_WIDTH);
  localparam int STEPS_EFF = CORDIC_STEPS > CORDIC_MAX ? CORDIC_MAX : CORDIC_STEPS;
  localparam longint COORD_HI  = (longint'(1) <<< (CW_EFF - 1)) - 1;
  localparam longint ONE       = longint'(ONE_Q30);
  localparam longint WORD_HI   = 64'sd2147483647;
  localparam longint HALF_Q30  = 64'sd536870912;

  typedef struct packed {
    logic [31:0] z;
    logic [31:0] y;
    logic [31:0] x;
  } point_t;

  typedef struct packed {
    logic [6:0]  pad;
    logic        ovf;
    logic [31:0] dz;
    logic [31:0] dy;
    logic [31:0] dx;
    logic [31:0] nz;
    logic [31:0] ny;
    logic [31:0] nx;
  } rotated_t;

  // arctangent of 2^-i in 2^-32 of a turn
  logic [31:0] atan_turns [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087, 32'd667544,
    32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861, 32'd10430, 32'd5215,
    32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81, 32'd41, 32'd20, 32'd10,
    32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  logic [31:0] axis_q30 [3];
  logic [31:0] angle_turn;
  logic [31:0] center [3];
  longint      model_matrix [9];
  rotated_t    rotated_q [$];
  int          errors = 0;

  function automatic longint round_q30(longint v);
    return (v + HALF_Q30) >>> 30;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint widen_coord(logic [31:0] v);
    longint t;
    t = longint'($signed(v));
    return (t <<< (64 - CW_EFF)) >>> (64 - CW_EFF);
  endfunction

  function automatic logic [31:0] saturate(longint v, inout logic ovf);
    if (v > COORD_HI) begin
      ovf = 1'b1;
      return COORD_HI[31:0];
    end
    if (v < -COORD_HI - 1) begin
      ovf = 1'b1;
      return 32'(-COORD_HI - 1);
    end
    return v[31:0];
  endfunction

  function automatic void rebuild_matrix();
    logic   flip;
    longint z, x, y, dx, dy, step, a, b, c, d;
    longint m [9];
    int     i;
    flip = angle_turn[31];
    z = flip ? (longint'(1) <<< 32) - longint'(angle_turn) : longint'(angle_turn);
    x = longint'(CORDIC_INV_GAIN);
    y = 0;
    for (i = 0; i < STEPS_EFF; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      step = 2 * longint'(atan_turns[i]);
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - step;
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + step;
      end
    end
    // past a quarter turn of half angle: supplementary angle, negated cosine
    a = clip(flip ? -x : x, -ONE, ONE);
    b = clip(-round_q30(longint'($signed(axis_q30[0])) * y), -ONE, ONE);
    c = clip(-round_q30(longint'($signed(axis_q30[1])) * y), -ONE, ONE);
    d = clip(-round_q30(longint'($signed(axis_q30[2])) * y), -ONE, ONE);
    m[0] = a*a + b*b - c*c - d*d;
    m[1] = 2 * (b*c - a*d);
    m[2] = 2 * (b*d + a*c);
    m[3] = 2 * (b*c + a*d);
    m[4] = a*a + c*c - b*b - d*d;
    m[5] = 2 * (c*d - a*b);
    m[6] = 2 * (b*d - a*c);
    m[7] = 2 * (c*d + a*b);
    m[8] = a*a + d*d - b*b - c*c;
    for (i = 0; i < 9; i++)
      model_matrix[i] = clip(round_q30(m[i]), -WORD_HI - 1, WORD_HI);
  endfunction

  function automatic void reset_model();
    int i;
    axis_q30[0] = '0;
    axis_q30[1] = '0;
    axis_q30[2] = ONE_Q30;
    angle_turn = '0;
    for (i = 0; i < 3; i++)
      center[i] = '0;
    for (i = 0; i < 9; i++)
      model_matrix[i] = (i % 4 == 0) ? ONE : 0;
  endfunction

  function automatic void apply_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    case (idx)
      REG_AXIS_X: begin
        axis_q30[0] = val;
        rebuild_matrix();
      end
      REG_AXIS_Y: begin
        axis_q30[1] = val;
        rebuild_matrix();
      end
      REG_AXIS_Z: begin
        axis_q30[2] = val;
        rebuild_matrix();
      end
      REG_ANGLE: begin
        angle_turn = val;
        rebuild_matrix();
      end
      REG_CENTER_X: center[0] = val;
      REG_CENTER_Y: center[1] = val;
      REG_CENTER_Z: center[2] = val;
      default: ;  // unused index: drop the write
    endcase
  endfunction

  function automatic rotated_t rotate_point(point_t pt);
    rotated_t    r;
    longint      p [3];
    longint      cen [3];
    longint      q [3];
    logic [31:0] new_c [3];
    logic [31:0] disp_c [3];
    longint      acc_hi, acc_lo, mh, ml, rot, nv;
    logic        ovf;
    int          i, j;
    ovf = 1'b0;
    p[0] = widen_coord(pt.x);
    p[1] = widen_coord(pt.y);
    p[2] = widen_coord(pt.z);
    for (i = 0; i < 3; i++) begin
      cen[i] = longint'($signed(center[i]));
      q[i] = p[i] - cen[i];
    end
    for (j = 0; j < 3; j++) begin
      acc_hi = 0;
      acc_lo = 0;
      // split each entry so that every partial product stays narrow
      for (i = 0; i < 3; i++) begin
        mh = model_matrix[3*i + j] >>> 15;
        ml = model_matrix[3*i + j] - mh * 32768;
        acc_hi = acc_hi + q[i] * mh;
        acc_lo = acc_lo + q[i] * ml;
      end
      rot = (acc_hi + ((acc_lo + HALF_Q30) >>> 15)) >>> 15;
      nv = rot + cen[j];
      // displacement uses the unsaturated rotated point
      new_c[j] = saturate(nv, ovf);
      disp_c[j] = saturate(nv - p[j], ovf);
    end
    r.pad = '0;
    r.ovf = ovf;
    r.nx = new_c[0];
    r.ny = new_c[1];
    r.nz = new_c[2];
    r.dx = disp_c[0];
    r.dy = disp_c[1];
    r.dz = disp_c[2];
    return r;
  endfunction

  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      if (errors < 10)
        $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    rotated_t got;
    rotated_t want;
    if (rst) begin
      reset_model();
      rotated_q.delete();
    end else begin
      if (cfg_wr_en)
        apply_write(cfg_index, cfg_data);
      if (s_axis_tvalid && s_axis_tready)
        rotated_q.push_back(rotate_point(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (rotated_q.size() == 0) begin
          if (errors < 10)
            $display("%0t: result with nothing pending: %h", $realtime, got);
          errors++;
        end else begin
          want = rotated_q.pop_front();
          check_field("new_x", want.nx, got.nx);
          check_field("new_y", want.ny, got.ny);
          check_field("new_z", want.nz, got.nz);
          check_field("disp_x", want.dx, got.dx);
          check_field("disp_y", want.dy, got.dy);
          check_field("disp_z", want.dz, got.dz);
          check_field("overflow", 32'(want.ovf), 32'(got.ovf));
          check_field("padding", 32'(want.pad), 32'(got.pad));
        end
      end
    end
    fail_count <= errors;
    pending <= rotated_q.size();
  end

endmodule

FILE: bench/tb_top.sv
// Top of the quaternion point rotator testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
  import qpr_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic [31:0] C_MAX    = 32'h7FFF_FFFF;
  localparam logic [31:0] C_MIN    = 32'h8000_0000;
  localparam logic [31:0] C_NEG1   = 32'hFFFF_FFFF;
  localparam logic [31:0] Q30_POS  = 32'h4000_0000;
  localparam logic [31:0] Q30_NEG  = 32'hC000_0000;
  localparam int          IDLE_PCT = 31;
  localparam int          PHASES   = 8;
  localparam int          PER_PHASE = 125;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WORD_W-1:0]    cfg_data = '0;
  logic                 s_axis_tvalid = 1'b0;
  wire                  s_axis_tready;
  logic [95:0]          s_axis_tdata = '0;
  wire                  m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  wire  [199:0]         m_axis_tdata;
  logic                 steady = 1'b0;  // no idling on either side
  int                   fail_count;
  int                   pending;

  quaternion_point_rotator dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  rotator_checker chk (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("Some tests failed");
    $finish;
  end

  always @(posedge clk)
    m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);

  function automatic logic [95:0] pt3(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    return {z, y, x};
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(19))
      0: return C_MAX;
      1: return C_MIN;
      2: return '0;
      3: return C_NEG1;
      4, 5, 6, 7, 8: return $urandom();
      9, 10: return $urandom_range(32'h2000_0000) - 32'h1000_0000;
      default: return $urandom_range(32'h0020_0000) - 32'h0010_0000;
    endcase
  endfunction

  function automatic logic [31:0] rand_axis();
    case ($urandom_range(3))
      0: return Q30_POS;
      1: return Q30_NEG;
      2: return '0;
      default: return $urandom_range(32'h8000_0000) - Q30_POS;
    endcase
  endfunction

  function automatic logic [31:0] rand_angle();
    case ($urandom_range(11))
      0: return '0;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      3: return 32'h7FFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] rand_center();
    if ($urandom_range(9) == 0)
      return $urandom();
    return $urandom_range(32'h0200_0000) - 32'h0100_0000;
  endfunction

  task automatic send_point(input logic [95:0] pt);
    if (!steady) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= pt;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    // hold off until any matrix rebuild has finished
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic apply_setting(input logic [31:0] ax, input logic [31:0] ay,
                               input logic [31:0] az, input logic [31:0] ang,
                               input logic [31:0] cx, input logic [31:0] cy,
                               input logic [31:0] cz);
    write_reg(REG_AXIS_X, ax);
    write_reg(REG_AXIS_Y, ay);
    write_reg(REG_AXIS_Z, az);
    write_reg(REG_ANGLE, ang);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_CENTER_Z, cz);
  endtask

  initial begin
    int  ph;
    int  k;
    logic full;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // identity matrix straight out of reset
    send_point(pt3('0, '0, '0));
    send_point(pt3(C_MAX, C_MIN, 32'h0000_0001));
    send_point(pt3(C_MIN, C_MAX, C_NEG1));
    send_point(pt3(32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_0000));
    drain();

    // quarter turn about +z
    apply_setting('0, '0, Q30_POS, 32'h4000_0000, '0, '0, '0);
    send_point(pt3(C_MAX, C_MIN, '0));
    send_point(pt3(C_MIN, C_MAX, '0));
    send_point(pt3(32'h0001_0000, 32'h0002_0000, 32'h0003_0000));
    drain();

    // half turn about -x: half angle sits on the quarter-turn boundary
    apply_setting(Q30_NEG, '0, '0, 32'h8000_0000, '0, '0, '0);
    send_point(pt3(C_MAX, C_MAX, C_MAX));
    send_point(pt3(C_MIN, C_MIN, C_MIN));
    send_point(pt3(32'h0005_8000, 32'hFFF3_0000, 32'h0000_0001));
    drain();

    // non-unit axis, angle just short of a full turn
    apply_setting(Q30_POS, Q30_POS, Q30_POS, 32'hFFFF_FFFF, '0, '0, '0);
    send_point(pt3(32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
    send_point(pt3(C_MAX, '0, C_MIN));
    send_point(pt3(32'h1234_5678, 32'h9ABC_DEF0, 32'h0FED_CBA9));
    drain();

    // unused index, then an extreme center that forces saturation
    write_reg(REG_UNUSED, 32'hDEAD_BEEF);
    apply_setting('0, Q30_NEG, '0, 32'h2AAA_AAAB, C_MAX, C_MIN, C_MAX);
    send_point(pt3(C_MIN, C_MAX, '0));
    send_point(pt3('0, '0, '0));
    send_point(pt3(C_MAX, C_MAX, C_MAX));
    drain();

    // just past the half-angle quarter turn
    apply_setting('0, Q30_POS, '0, 32'h8000_0001, '0, '0, '0);
    send_point(pt3(32'h0010_0000, C_NEG1, 32'hFFF0_0000));
    send_point(pt3(C_MIN, C_MAX, C_NEG1));
    drain();

    for (ph = 0; ph < PHASES; ph++) begin
      full = (ph == 0);
      steady <= (ph == 3);
      if (full || $urandom_range(1)) write_reg(REG_AXIS_X, rand_axis());
      if (full || $urandom_range(1)) write_reg(REG_AXIS_Y, rand_axis());
      if (full || $urandom_range(1)) write_reg(REG_AXIS_Z, rand_axis());
      if (full || $urandom_range(3) != 0) write_reg(REG_ANGLE, rand_angle());
      if (full || $urandom_range(1)) write_reg(REG_CENTER_X, rand_center());
      if (full || $urandom_range(1)) write_reg(REG_CENTER_Y, rand_center());
      if (full || $urandom_range(1)) write_reg(REG_CENTER_Z, rand_center());
      if ($urandom_range(3) == 0) write_reg(REG_UNUSED, $urandom());
      for (k = 0; k < PER_PHASE; k++)
        send_point(pt3(rand_coord(), rand_coord(), rand_coord()));
      drain();
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/qpr_pkg.sv
design/qpr_builder.sv
design/qpr_datapath.sv
design/quaternion_point_rotator.sv
bench/rotator_checker.sv
bench/tb_top.sv
